// ===== src/mgut_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mgut_pkg
// Shared types and constants for the motion-gated update trigger.
// ----------------------------------------------------------------------------
package mgut_pkg;

  localparam int MODE_BITS     = 2;
  localparam int RATE_BITS     = 24;
  localparam int HOLD_BITS     = 32;
  localparam int DIST_SQ_BITS  = 51;
  localparam int INTERVAL_BITS = 32;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 6;
  localparam int REG_IDX_BITS  = 3;
  localparam int OUT_BITS      = 8;

  // turn rate limit out of reset, 2^23
  localparam logic [RATE_BITS-1:0] TURN_RATE_RST = 24'h800000;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ODOM       = 2'd0,
    MODE_SCAN_DONE  = 2'd1,
    MODE_TIME_CHECK = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_MAX_TURN_RATE    = 3'd0,
    REG_IDLE_HOLD_MS     = 3'd1,
    REG_IDLE_EXIT_DIST   = 3'd2,
    REG_MIN_MOVE_DIST    = 3'd3,
    REG_MIN_TURN_ANGLE   = 3'd4,
    REG_MIN_SCAN_INTERVAL = 3'd5
  } reg_idx_t;

  // thresholds whose widths do not follow the module parameters
  typedef struct packed {
    logic [RATE_BITS-1:0]     max_turn_rate;
    logic [HOLD_BITS-1:0]     idle_hold_ms;
    logic [DIST_SQ_BITS-1:0]  idle_exit_dist_sq;
    logic [DIST_SQ_BITS-1:0]  min_move_dist_sq;
    logic [INTERVAL_BITS-1:0] min_scan_interval_ms;
  } cfg_t;

  // last member lands in bit 0
  typedef struct packed {
    logic awaiting_reference;
    logic time_elapsed;
    logic moved_enough;
    logic idle_now;
  } flags_t;

endpackage : mgut_pkg
`default_nettype wire

// ===== src/mgut_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mgut_regs
// APB register file holding the trigger thresholds.
// ----------------------------------------------------------------------------
module mgut_regs #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mgut_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [mgut_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [mgut_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output mgut_pkg::cfg_t                          cfg,
  output logic      [ANGLE_BITS-1:0]              min_turn_angle
);
  import mgut_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-REG_IDX_BITS]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_turn_rate        <= TURN_RATE_RST;
      cfg.idle_hold_ms         <= '0;
      cfg.idle_exit_dist_sq    <= '0;
      cfg.min_move_dist_sq     <= '0;
      cfg.min_scan_interval_ms <= '0;
      min_turn_angle           <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_TURN_RATE:     cfg.max_turn_rate        <= pwdata[RATE_BITS-1:0];
        REG_IDLE_HOLD_MS:      cfg.idle_hold_ms         <= pwdata[HOLD_BITS-1:0];
        REG_IDLE_EXIT_DIST:    cfg.idle_exit_dist_sq    <= pwdata[DIST_SQ_BITS-1:0];
        REG_MIN_MOVE_DIST:     cfg.min_move_dist_sq     <= pwdata[DIST_SQ_BITS-1:0];
        REG_MIN_TURN_ANGLE:    min_turn_angle           <= pwdata[ANGLE_BITS-1:0];
        REG_MIN_SCAN_INTERVAL: cfg.min_scan_interval_ms <= pwdata[INTERVAL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_MAX_TURN_RATE:     prdata[RATE_BITS-1:0]     = cfg.max_turn_rate;
      REG_IDLE_HOLD_MS:      prdata[HOLD_BITS-1:0]     = cfg.idle_hold_ms;
      REG_IDLE_EXIT_DIST:    prdata[DIST_SQ_BITS-1:0]  = cfg.idle_exit_dist_sq;
      REG_MIN_MOVE_DIST:     prdata[DIST_SQ_BITS-1:0]  = cfg.min_move_dist_sq;
      REG_MIN_TURN_ANGLE:    prdata[ANGLE_BITS-1:0]    = min_turn_angle;
      REG_MIN_SCAN_INTERVAL: prdata[INTERVAL_BITS-1:0] = cfg.min_scan_interval_ms;
      default:               prdata = '0;
    endcase
  end

endmodule : mgut_regs
`default_nettype wire

// ===== src/mgut_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mgut_core
// Trigger state and its combinational next-state logic for one registered word.
// ----------------------------------------------------------------------------
module mgut_core #(
  parameter int POS_BITS   = 24,
  parameter int TIME_BITS  = 32,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                fire,
  input  wire logic [mgut_pkg::MODE_BITS-1:0]      mode,
  input  wire logic [TIME_BITS-1:0]                time_ms,
  input  wire logic signed [POS_BITS-1:0]          pos_x_mm,
  input  wire logic signed [POS_BITS-1:0]          pos_y_mm,
  input  wire logic [ANGLE_BITS-1:0]               yaw_angle,
  input  wire logic signed [mgut_pkg::RATE_BITS-1:0] yaw_rate,
  input  wire mgut_pkg::cfg_t                      cfg,
  input  wire logic [ANGLE_BITS-1:0]               min_turn_angle,
  output mgut_pkg::flags_t                         flags_next
);
  import mgut_pkg::*;

  localparam int SQ_BITS   = 2 * POS_BITS + 1;
  localparam int CMP_BITS  = (SQ_BITS > DIST_SQ_BITS) ? SQ_BITS : DIST_SQ_BITS;
  localparam int TW_BITS   = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;
  localparam int IV_BITS   = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;

  // state
  logic                        idle_flag;
  logic [TIME_BITS:0]          idle_end_time;
  logic signed [POS_BITS-1:0]  idle_ref_x;
  logic signed [POS_BITS-1:0]  idle_ref_y;
  logic signed [POS_BITS-1:0]  ref_x;
  logic signed [POS_BITS-1:0]  ref_y;
  logic [ANGLE_BITS-1:0]       ref_yaw;
  logic                        need_reference;
  logic                        moved_flag;
  logic                        elapsed_flag;
  logic [TIME_BITS-1:0]        last_scan_time;

  logic                        idle_flag_next;
  logic [TIME_BITS:0]          idle_end_time_next;
  logic                        idle_ref_load;
  logic                        ref_load;
  logic                        need_reference_next;
  logic                        moved_flag_next;
  logic                        elapsed_flag_next;
  logic [TIME_BITS-1:0]        last_scan_time_next;

  mode_t                       mode_c;
  logic [RATE_BITS-1:0]        rate_abs;
  logic                        fast_turn;

  // one shared squared-distance unit, reference picked by idle state
  logic signed [POS_BITS-1:0]  cmp_x;
  logic signed [POS_BITS-1:0]  cmp_y;
  logic signed [POS_BITS:0]    diff_x;
  logic signed [POS_BITS:0]    diff_y;
  logic [POS_BITS-1:0]         abs_x;
  logic [POS_BITS-1:0]         abs_y;
  logic [2*POS_BITS-1:0]       sq_x;
  logic [2*POS_BITS-1:0]       sq_y;
  logic [SQ_BITS-1:0]          dist_sq;
  logic [DIST_SQ_BITS-1:0]     dist_limit;
  logic                        dist_reached;

  logic [ANGLE_BITS-1:0]       yaw_d;
  logic [ANGLE_BITS:0]         yaw_d_ext;
  logic [ANGLE_BITS:0]         yaw_d_rev;
  logic [ANGLE_BITS:0]         turn;

  logic [TW_BITS:0]            end_sum;
  logic [TIME_BITS-1:0]        since_scan;
  logic                        interval_met;
  logic                        idle_exit_ok;

  assign mode_c    = mode_t'(mode);
  assign rate_abs  = yaw_rate[RATE_BITS-1] ? RATE_BITS'(-yaw_rate) : RATE_BITS'(yaw_rate);
  assign fast_turn = rate_abs >= cfg.max_turn_rate;

  assign cmp_x  = idle_flag ? idle_ref_x : ref_x;
  assign cmp_y  = idle_flag ? idle_ref_y : ref_y;
  assign diff_x = {pos_x_mm[POS_BITS-1], pos_x_mm} - {cmp_x[POS_BITS-1], cmp_x};
  assign diff_y = {pos_y_mm[POS_BITS-1], pos_y_mm} - {cmp_y[POS_BITS-1], cmp_y};
  assign abs_x  = diff_x[POS_BITS] ? POS_BITS'(-diff_x) : diff_x[POS_BITS-1:0];
  assign abs_y  = diff_y[POS_BITS] ? POS_BITS'(-diff_y) : diff_y[POS_BITS-1:0];
  assign sq_x   = abs_x * abs_x;
  assign sq_y   = abs_y * abs_y;
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign dist_limit   = idle_flag ? cfg.idle_exit_dist_sq : cfg.min_move_dist_sq;
  assign dist_reached = CMP_BITS'(dist_sq) >= CMP_BITS'(dist_limit);

  // wrapped heading change, half turn counts in full
  assign yaw_d     = ref_yaw - yaw_angle;
  assign yaw_d_ext = {1'b0, yaw_d};
  assign yaw_d_rev = {1'b1, {ANGLE_BITS{1'b0}}} - yaw_d_ext;
  assign turn      = (yaw_d_ext <= yaw_d_rev) ? yaw_d_ext : yaw_d_rev;

  assign end_sum      = (TW_BITS+1)'(time_ms) + (TW_BITS+1)'(cfg.idle_hold_ms);
  assign since_scan   = time_ms - last_scan_time;
  assign interval_met = (time_ms >= last_scan_time) &&
                        (IV_BITS'(since_scan) >= IV_BITS'(cfg.min_scan_interval_ms));
  assign idle_exit_ok = ({1'b0, time_ms} > idle_end_time) && dist_reached;

  always_comb begin
    idle_flag_next      = idle_flag;
    idle_end_time_next  = idle_end_time;
    idle_ref_load       = 1'b0;
    ref_load            = 1'b0;
    need_reference_next = need_reference;
    moved_flag_next     = moved_flag;
    elapsed_flag_next   = elapsed_flag;
    last_scan_time_next = last_scan_time;
    case (mode_c)
      MODE_ODOM: begin
        if (fast_turn) begin
          idle_flag_next      = 1'b1;
          idle_end_time_next  = end_sum[TIME_BITS:0];
          idle_ref_load       = 1'b1;
          last_scan_time_next = time_ms;
          elapsed_flag_next   = 1'b0;
          need_reference_next = 1'b1;
          moved_flag_next     = 1'b0;
        end else if (idle_flag) begin
          if (idle_exit_ok) begin
            idle_flag_next      = 1'b0;
            last_scan_time_next = time_ms;
            elapsed_flag_next   = 1'b0;
            need_reference_next = 1'b1;
            moved_flag_next     = 1'b0;
          end
        end else if (need_reference) begin
          ref_load            = 1'b1;
          need_reference_next = 1'b0;
        end else if (!moved_flag) begin
          if (dist_reached || ({1'b0, turn} >= {2'b00, min_turn_angle})) begin
            moved_flag_next = 1'b1;
          end
        end
      end
      MODE_SCAN_DONE: begin
        last_scan_time_next = time_ms;
        elapsed_flag_next   = 1'b0;
        need_reference_next = 1'b1;
        moved_flag_next     = 1'b0;
      end
      MODE_TIME_CHECK: begin
        if (!elapsed_flag && interval_met) begin
          elapsed_flag_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    flags_next.idle_now           = idle_flag_next;
    flags_next.moved_enough       = moved_flag_next;
    flags_next.time_elapsed       = elapsed_flag_next;
    flags_next.awaiting_reference = need_reference_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_flag      <= 1'b0;
      idle_end_time  <= '0;
      idle_ref_x     <= '0;
      idle_ref_y     <= '0;
      ref_x          <= '0;
      ref_y          <= '0;
      ref_yaw        <= '0;
      need_reference <= 1'b1;
      moved_flag     <= 1'b0;
      elapsed_flag   <= 1'b0;
      last_scan_time <= '0;
    end else if (fire) begin
      idle_flag      <= idle_flag_next;
      idle_end_time  <= idle_end_time_next;
      need_reference <= need_reference_next;
      moved_flag     <= moved_flag_next;
      elapsed_flag   <= elapsed_flag_next;
      last_scan_time <= last_scan_time_next;
      if (idle_ref_load) begin
        idle_ref_x <= pos_x_mm;
        idle_ref_y <= pos_y_mm;
      end
      if (ref_load) begin
        ref_x   <= pos_x_mm;
        ref_y   <= pos_y_mm;
        ref_yaw <= yaw_angle;
      end
    end
  end

endmodule : mgut_core
`default_nettype wire

// ===== src/motion_gated_update_trigger_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motion_gated_update_trigger_top
// Decides when a new scan may be processed from odometry, scan-done and
// time-check words; reports idle, moved, elapsed and reference flags.
//
//   channel  dir  handshake          contents
//   s_*      in   s_tvalid/s_tready  tuser mode, tdata time/pose/yaw/rate
//   m_*      out  m_tvalid/m_tready  tdata four status flags
//   apb      in   psel/penable       six threshold registers at 8*i
//
// One word per cycle unless the output stalls: an input register, one pass of
// compare logic with two squarings, and an output register. A flag word is
// registered, and the state updated, as its word leaves the input register.
// A stalled output holds the input register; s_tready drops only while both
// stages are full and m_tready is low. rst is synchronous and clears the valid
// bits, the thresholds and the trigger state.
module motion_gated_update_trigger_top #(
  parameter int POS_BITS   = 24,
  parameter int TIME_BITS  = 32,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // time_ms, pos_x_mm, pos_y_mm, yaw_angle, yaw_rate (lowest bit up)
  input  wire logic [8*((TIME_BITS+2*POS_BITS+ANGLE_BITS+mgut_pkg::RATE_BITS+7)/8)-1:0]
                                                   s_tdata,
  // mode
  input  wire logic [mgut_pkg::MODE_BITS-1:0]      s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // idle_now, moved_enough, time_elapsed, awaiting_reference (lowest bit up)
  output logic [mgut_pkg::OUT_BITS-1:0]            m_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mgut_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [mgut_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [mgut_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready
);
  import mgut_pkg::*;

  localparam int X_LSB    = TIME_BITS;
  localparam int Y_LSB    = X_LSB + POS_BITS;
  localparam int YAW_LSB  = Y_LSB + POS_BITS;
  localparam int RATE_LSB = YAW_LSB + ANGLE_BITS;

  cfg_t                          cfg;
  logic [ANGLE_BITS-1:0]         min_turn_angle;
  flags_t                        flags_next;

  // input register
  logic                          in_valid;
  logic [MODE_BITS-1:0]          in_mode;
  logic [TIME_BITS-1:0]          in_time;
  logic signed [POS_BITS-1:0]    in_x;
  logic signed [POS_BITS-1:0]    in_y;
  logic [ANGLE_BITS-1:0]         in_yaw;
  logic signed [RATE_BITS-1:0]   in_rate;

  logic                          advance;
  logic                          s_fire;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_mode <= s_tuser;
      in_time <= s_tdata[TIME_BITS-1:0];
      in_x    <= s_tdata[X_LSB +: POS_BITS];
      in_y    <= s_tdata[Y_LSB +: POS_BITS];
      in_yaw  <= s_tdata[YAW_LSB +: ANGLE_BITS];
      in_rate <= s_tdata[RATE_LSB +: RATE_BITS];
    end
  end

  mgut_regs #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cfg           (cfg),
    .min_turn_angle(min_turn_angle)
  );

  mgut_core #(
    .POS_BITS  (POS_BITS),
    .TIME_BITS (TIME_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .mode          (in_mode),
    .time_ms       (in_time),
    .pos_x_mm      (in_x),
    .pos_y_mm      (in_y),
    .yaw_angle     (in_yaw),
    .yaw_rate      (in_rate),
    .cfg           (cfg),
    .min_turn_angle(min_turn_angle),
    .flags_next    (flags_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_BITS'(flags_next);
    end
  end

endmodule : motion_gated_update_trigger_top
`default_nettype wire
